@@ src/imu_rate_upsample_by_three_unit_defines.svh @@
// ----------------------------------------------------------------------------
// IMU rate upsampler - assertion macros
// Shared property shorthands; every user provides clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef IMU_RATE_UPSAMPLE_BY_THREE_UNIT_DEFINES_SVH
`define IMU_RATE_UPSAMPLE_BY_THREE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define IRU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define IRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/iru_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU rate upsampler - shared package
// Fixed widths, queue sizing, beat sequence type and queue status bundle.
// ----------------------------------------------------------------------------
package iru_pkg;

    // Timestamp field and its signed difference
    localparam int STAMP_W      = 63;
    localparam int STAMP_DIFF_W = STAMP_W + 1;

    // Number of rate axes carried per sample
    localparam int AXES = 3;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Register stages in the divide-by-three unit
    localparam int DIV_LAT = 4;

    // Position of the back end within one run of three results
    typedef enum logic [1:0] {
        BEAT_PREV,
        BEAT_ONE,
        BEAT_TWO
    } beat_t;

    // Queue status seen by both neighbours
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

@@ src/iru_div3.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU rate upsampler - divide by three
// Pipelined signed division by three, truncating toward zero. The magnitude
// is split into two chunks, each divided by a reciprocal multiply.
// ----------------------------------------------------------------------------
module iru_div3 #(
    parameter int DW = 33
) (
    input  logic          clk,
    input  logic          adv,
    input  logic [DW-1:0] diff,
    output logic [DW-1:0] step
);

    localparam int CW = (DW + 1) / 2;
    localparam int VW = CW + 2;
    localparam int SH = CW + 3;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << SH) + 64'd2) / 64'd3;
    localparam logic [VW-1:0] RECIP = RECIP_FULL[VW-1:0];

    logic [DW-1:0]     mag_c;
    logic [2*CW-1:0]   mag_reg;
    logic              sign_a_reg;

    logic [2*VW-1:0]   prod_b;
    logic [CW-1:0]     qhi_reg;
    logic [CW-1:0]     hi_reg;
    logic [CW-1:0]     lo_reg;
    logic              sign_b_reg;

    logic [CW+1:0]     rem_c;
    logic [VW-1:0]     v_c;
    logic [2*VW-1:0]   prod_c;
    logic [2*CW-1:0]   q_reg;
    logic              sign_c_reg;

    logic [DW-1:0]     q_dw;
    logic [DW-1:0]     step_next;
    logic [DW-1:0]     step_reg;

    // Take the magnitude of the difference
    always_comb
    begin
        mag_c = diff[DW-1] ? (~diff + {{(DW-1){1'b0}}, 1'b1}) : diff;
    end

    // Divide the upper chunk
    assign prod_b = {2'b00, mag_reg[2*CW-1:CW]} * RECIP;

    // Fold the upper remainder into the lower chunk and divide it
    always_comb
    begin
        rem_c  = {2'b00, hi_reg} - {2'b00, qhi_reg} - {1'b0, qhi_reg, 1'b0};
        v_c    = {rem_c[1:0], lo_reg};
        prod_c = v_c * RECIP;
    end

    // Restore the sign
    always_comb
    begin
        q_dw      = DW'(q_reg);
        step_next = sign_c_reg ? (~q_dw + {{(DW-1){1'b0}}, 1'b1}) : q_dw;
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg    <= (2*CW)'(mag_c);
            sign_a_reg <= diff[DW-1];

            qhi_reg    <= prod_b[SH +: CW];
            hi_reg     <= mag_reg[2*CW-1:CW];
            lo_reg     <= mag_reg[CW-1:0];
            sign_b_reg <= sign_a_reg;

            q_reg      <= {qhi_reg, prod_c[SH +: CW]};
            sign_c_reg <= sign_b_reg;

            step_reg   <= step_next;
        end
    end

    assign step = step_reg;

endmodule

@@ src/iru_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU rate upsampler - decoupling queue
// Short register queue holding prepared runs between front and back.
// ----------------------------------------------------------------------------
`include "imu_rate_upsample_by_three_unit_defines.svh"

module iru_queue #(
    parameter int W = 422
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [W-1:0]    push_data,
    input  logic            pop,
    output logic [W-1:0]    pop_data,
    output iru_pkg::q_stat_t stat
);

    localparam int DEPTH = iru_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [W-1:0]    mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;

    // Status flags
    assign stat.full  = (count_reg == CNTW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `IRU_ASSERT_NOW(a_no_pop_empty, pop, !stat.empty, "queue popped while empty")
    `IRU_ASSERT_NOW(a_no_push_full, push, !stat.full, "queue pushed while full")

endmodule

@@ src/iru_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU rate upsampler - front end
// Accepts samples, keeps the previous one, forms the differences and their
// thirds, and pushes one prepared run per sample pair into the queue.
// ----------------------------------------------------------------------------
`include "imu_rate_upsample_by_three_unit_defines.svh"

module iru_front #(
    parameter int RW = 32,
    parameter int EW = 422
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [iru_pkg::STAMP_W-1:0] in_stamp,
    input  logic [RW-1:0]              in_rate [iru_pkg::AXES],
    output logic                       push,
    output logic [EW-1:0]              push_data,
    input  iru_pkg::q_stat_t           q_stat
);

    localparam int SW   = iru_pkg::STAMP_W;
    localparam int DSW  = iru_pkg::STAMP_DIFF_W;
    localparam int NAX  = iru_pkg::AXES;
    localparam int LAT  = iru_pkg::DIV_LAT + 1;
    localparam int BR_O = SW;
    localparam int SS_O = SW + NAX * RW;
    localparam int SR_O = SS_O + DSW;

    logic                have_prev_reg;
    logic [SW-1:0]       prev_stamp_reg;
    logic [RW-1:0]       prev_rate_reg [NAX];

    logic [LAT-1:0]      vld_reg;
    logic [LAT-1:0]      vld_next;
    logic [SW-1:0]       base_stamp_reg [LAT];
    logic [RW-1:0]       base_rate_reg [LAT][NAX];
    logic [DSW-1:0]      dstamp_reg;
    logic [RW:0]         drate_reg [NAX];

    logic [DSW-1:0]      step_stamp;
    logic [RW:0]         step_rate [NAX];

    logic                adv;
    logic                accept;

    // Stall the whole pipeline only when a finished run cannot enter the queue
    assign adv      = !(vld_reg[LAT-1] && q_stat.full);
    assign in_ready = adv;
    assign accept   = in_valid && adv;
    assign push     = vld_reg[LAT-1] && !q_stat.full;
    assign vld_next = {vld_reg[LAT-2:0], accept && have_prev_reg};

    // Previous-sample store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
        end
        else if (accept)
        begin
            have_prev_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_stamp_reg <= in_stamp;
            for (int a = 0; a < NAX; a++)
            begin
                prev_rate_reg[a] <= in_rate[a];
            end
        end
    end

    // Valid bits of the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Form differences and carry the base sample alongside the divider
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dstamp_reg        <= {1'b0, in_stamp} - {1'b0, prev_stamp_reg};
            base_stamp_reg[0] <= prev_stamp_reg;
            for (int a = 0; a < NAX; a++)
            begin
                drate_reg[a]        <= {in_rate[a][RW-1], in_rate[a]}
                                     - {prev_rate_reg[a][RW-1], prev_rate_reg[a]};
                base_rate_reg[0][a] <= prev_rate_reg[a];
            end
            for (int t = 1; t < LAT; t++)
            begin
                base_stamp_reg[t] <= base_stamp_reg[t-1];
                for (int a = 0; a < NAX; a++)
                begin
                    base_rate_reg[t][a] <= base_rate_reg[t-1][a];
                end
            end
        end
    end

    // Thirds of the time step and of each rate step
    iru_div3 #(
        .DW (DSW)
    ) u_div_stamp (
        .clk  (clk),
        .adv  (adv),
        .diff (dstamp_reg),
        .step (step_stamp)
    );

    for (genvar g = 0; g < NAX; g++)
    begin : g_axis
        iru_div3 #(
            .DW (RW + 1)
        ) u_div_rate (
            .clk  (clk),
            .adv  (adv),
            .diff (drate_reg[g]),
            .step (step_rate[g])
        );
    end

    // Pack the run for the queue
    always_comb
    begin
        push_data = '0;
        push_data[0 +: SW]   = base_stamp_reg[LAT-1];
        push_data[SS_O +: DSW] = step_stamp;
        for (int a = 0; a < NAX; a++)
        begin
            push_data[BR_O + a*RW +: RW]       = base_rate_reg[LAT-1][a];
            push_data[SR_O + a*(RW+1) +: RW+1] = step_rate[a];
        end
    end

    `IRU_ASSERT_NEXT(a_first_no_run, accept && !have_prev_reg, !vld_reg[0],
        "first sample started a run")

endmodule

@@ src/iru_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU rate upsampler - back end
// Reads a prepared run from the queue and emits its three results through
// an output register, one per cycle while the sink takes them.
// ----------------------------------------------------------------------------
`include "imu_rate_upsample_by_three_unit_defines.svh"

module iru_back #(
    parameter int RW = 32,
    parameter int EW = 422
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  iru_pkg::q_stat_t            q_stat,
    input  logic [EW-1:0]               q_data,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [iru_pkg::STAMP_W-1:0] out_stamp,
    output logic [RW-1:0]               out_rate [iru_pkg::AXES],
    output logic                        out_last
);

    localparam int SW   = iru_pkg::STAMP_W;
    localparam int DSW  = iru_pkg::STAMP_DIFF_W;
    localparam int NAX  = iru_pkg::AXES;
    localparam int BR_O = SW;
    localparam int SS_O = SW + NAX * RW;
    localparam int SR_O = SS_O + DSW;

    iru_pkg::beat_t beat_reg;
    iru_pkg::beat_t beat_next;

    logic            load;
    logic            sel_one;
    logic            sel_two;
    logic            last_c;

    logic [DSW-1:0]  step_stamp;
    logic [DSW-1:0]  inc_stamp;
    logic [DSW-1:0]  sum_stamp;
    logic [RW+1:0]   inc_rate [NAX];
    logic [RW+1:0]   sum_rate [NAX];
    logic [RW:0]     step_rate;
    logic [RW-1:0]   base_rate;

    logic            out_valid_reg;
    logic [SW-1:0]   out_stamp_reg;
    logic [RW-1:0]   out_rate_reg [NAX];
    logic            out_last_reg;

    // Load the output register when it is free or being taken and the queue is not empty
    assign load = (!out_valid_reg || out_ready) && !q_stat.empty;

    // Beat sequence: next state
    always_comb
    begin
        beat_next = beat_reg;
        if (load)
        begin
            case (beat_reg)
                iru_pkg::BEAT_PREV: beat_next = iru_pkg::BEAT_ONE;
                iru_pkg::BEAT_ONE:  beat_next = iru_pkg::BEAT_TWO;
                iru_pkg::BEAT_TWO:  beat_next = iru_pkg::BEAT_PREV;
                default:            beat_next = iru_pkg::BEAT_PREV;
            endcase
        end
    end

    // Beat sequence: outputs
    always_comb
    begin
        sel_one = 1'b0;
        sel_two = 1'b0;
        last_c  = 1'b0;
        case (beat_reg)
            iru_pkg::BEAT_PREV: ;
            iru_pkg::BEAT_ONE:  sel_one = 1'b1;
            iru_pkg::BEAT_TWO:
            begin
                sel_two = 1'b1;
                last_c  = 1'b1;
            end
            default: ;
        endcase
        pop = load && last_c;
    end

    // Base plus none, one or two steps
    always_comb
    begin
        step_stamp = q_data[SS_O +: DSW];
        inc_stamp  = sel_two ? {step_stamp[DSW-2:0], 1'b0}
                   : (sel_one ? step_stamp : '0);
        sum_stamp  = {1'b0, q_data[0 +: SW]} + inc_stamp;
        step_rate  = '0;
        base_rate  = '0;
        for (int a = 0; a < NAX; a++)
        begin
            step_rate   = q_data[SR_O + a*(RW+1) +: RW+1];
            base_rate   = q_data[BR_O + a*RW +: RW];
            inc_rate[a] = sel_two ? {step_rate, 1'b0}
                        : (sel_one ? {step_rate[RW], step_rate} : '0);
            sum_rate[a] = {base_rate[RW-1], base_rate[RW-1], base_rate} + inc_rate[a];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg      <= iru_pkg::BEAT_PREV;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            beat_reg <= beat_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_stamp_reg <= sum_stamp[SW-1:0];
            out_last_reg  <= last_c;
            for (int a = 0; a < NAX; a++)
            begin
                out_rate_reg[a] <= sum_rate[a][RW-1:0];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_stamp = out_stamp_reg;
    assign out_rate  = out_rate_reg;
    assign out_last  = out_last_reg;

    `IRU_ASSERT_NOW(a_last_ends_run, out_valid_reg && out_last_reg,
        beat_reg == iru_pkg::BEAT_PREV, "run end not followed by a fresh run")
    `IRU_ASSERT_NOW(a_mid_run, out_valid_reg && !out_last_reg,
        beat_reg == iru_pkg::BEAT_ONE || beat_reg == iru_pkg::BEAT_TWO,
        "inner result shown with no run in progress")

endmodule

@@ src/imu_rate_upsample_by_three_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU rate upsampler by three - top level
// Linear interpolation of timestamped three-axis gyro rates: each sample
// after the first yields the previous sample and the points at one and two
// thirds of the way toward the new one.
//
//   Port group   Dir  Contents
//   s_axis_*     in   one gyro sample: stamp, x, y, z rates
//   m_axis_*     out  one result; tlast on the third result of a run
//
// The back end emits one result per cycle while the sink takes them, and each
// sample after the first yields a run of three results. An accepted sample
// reaches its run's first result through the difference stage, four divider
// stages, the queue and the output register.
// Reset clears control only; no clearing pass, s_axis_tready is high straight
// out of reset.
// A stalled sink fills the two-entry queue, then the front pipeline holds
// and s_axis_tready falls; the front keeps accepting while results wait.
// ----------------------------------------------------------------------------
module imu_rate_upsample_by_three_unit #(
    parameter int RATE_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,

    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // stamp_ns, rate_x, rate_y, rate_z (low bits first), zero padded
    input  logic [((iru_pkg::STAMP_W + iru_pkg::AXES * RATE_WIDTH + 7) / 8) * 8 - 1:0]
                 s_axis_tdata,

    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // out_stamp_ns, out_rate_x, out_rate_y, out_rate_z (low bits first), zero padded
    output logic [((iru_pkg::STAMP_W + iru_pkg::AXES * RATE_WIDTH + 7) / 8) * 8 - 1:0]
                 m_axis_tdata,
    // last_of_run
    output logic m_axis_tlast
);

    localparam int SW  = iru_pkg::STAMP_W;
    localparam int NAX = iru_pkg::AXES;
    localparam int PW  = SW + NAX * RATE_WIDTH;
    localparam int TW  = ((PW + 7) / 8) * 8;
    localparam int EW  = SW + NAX * RATE_WIDTH + iru_pkg::STAMP_DIFF_W
                       + NAX * (RATE_WIDTH + 1);

    logic [SW-1:0]         in_stamp;
    logic [RATE_WIDTH-1:0] in_rate [NAX];
    logic [SW-1:0]         out_stamp;
    logic [RATE_WIDTH-1:0] out_rate [NAX];
    logic [PW-1:0]         out_bits;

    logic                  push;
    logic [EW-1:0]         push_data;
    logic                  pop;
    logic [EW-1:0]         pop_data;
    iru_pkg::q_stat_t      q_stat;

    // Unpack the input transfer
    always_comb
    begin
        in_stamp = s_axis_tdata[0 +: SW];
        for (int a = 0; a < NAX; a++)
        begin
            in_rate[a] = s_axis_tdata[SW + a*RATE_WIDTH +: RATE_WIDTH];
        end
    end

    iru_front #(
        .RW (RATE_WIDTH),
        .EW (EW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_stamp  (in_stamp),
        .in_rate   (in_rate),
        .push      (push),
        .push_data (push_data),
        .q_stat    (q_stat)
    );

    iru_queue #(
        .W (EW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    iru_back #(
        .RW (RATE_WIDTH),
        .EW (EW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_data    (pop_data),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_stamp (out_stamp),
        .out_rate  (out_rate),
        .out_last  (m_axis_tlast)
    );

    // Pack the output transfer
    always_comb
    begin
        out_bits = '0;
        out_bits[0 +: SW] = out_stamp;
        for (int a = 0; a < NAX; a++)
        begin
            out_bits[SW + a*RATE_WIDTH +: RATE_WIDTH] = out_rate[a];
        end
        m_axis_tdata = TW'(out_bits);
    end

endmodule
